[design/ps2_mouse_packet_tracker_top_macros.svh]
// Assertion macros used by the PS/2 mouse packet tracker checker.
`ifndef PS2_MOUSE_PACKET_TRACKER_TOP_MACROS_SVH
`define PS2_MOUSE_PACKET_TRACKER_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define PS2MT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ps2mt checker: property failed");

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define PS2MT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ps2mt checker: property failed");

`endif

[design/ps2mt_pkg.sv]
// Types and constants for the PS/2 mouse packet tracker.
package ps2mt_pkg;

    localparam int LIMIT_W = 12;
    localparam int OUT_W   = 12;

    localparam logic [LIMIT_W-1:0] X_LIMIT_RESET = 12'd784;
    localparam logic [LIMIT_W-1:0] Y_LIMIT_RESET = 12'd584;

    // Header byte bit positions.
    localparam int HDR_SYNC_BIT = 3;
    localparam int HDR_XSGN_BIT = 4;
    localparam int HDR_YSGN_BIT = 5;
    localparam int HDR_BTN1_BIT = 0;
    localparam int HDR_BTN2_BIT = 1;
    localparam int HDR_BTN3_BIT = 2;

    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_BTN1 = 2'd1;
    localparam logic [1:0] HELD_BTN2 = 2'd2;
    localparam logic [1:0] HELD_BTN3 = 2'd3;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_XBYTE  = 2'd1,
        PH_YBYTE  = 2'd2
    } t_phase;

    typedef enum logic {
        CFG_X_LIMIT = 1'b0,
        CFG_Y_LIMIT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] header;
        logic [7:0] xbyte;
        logic [7:0] ybyte;
    } t_packet;

    typedef struct packed {
        logic [OUT_W-1:0] cursor_x;
        logic [OUT_W-1:0] cursor_y;
        logic [1:0]       held_button;
        logic             button_change;
        logic [2:0]       down_edges;
        logic [2:0]       up_edges;
    } t_result;

endpackage

[design/ps2mt_if.sv]
// Channel interfaces of the PS/2 mouse packet tracker: bytes, results, configuration.
interface ps2mt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ps2mt_result_if;
    logic                         valid;
    logic                         ready;
    logic [ps2mt_pkg::OUT_W-1:0] cursor_x;
    logic [ps2mt_pkg::OUT_W-1:0] cursor_y;
    logic [1:0]                   held_button;
    logic                         button_change;
    logic [2:0]                   down_edges;
    logic [2:0]                   up_edges;

    modport source (
        output valid, output cursor_x, output cursor_y, output held_button,
        output button_change, output down_edges, output up_edges, input ready
    );
    modport sink (
        input valid, input cursor_x, input cursor_y, input held_button,
        input button_change, input down_edges, input up_edges, output ready
    );
endinterface

interface ps2mt_cfg_if;
    logic                           valid;
    logic                           ready;
    ps2mt_pkg::t_cfg_idx            index;
    logic [ps2mt_pkg::LIMIT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/ps2mt_framer.sv]
// Three-byte packet framer: tracks the byte phase and registers each complete packet.
module ps2mt_framer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    input  logic                i_adv,
    output logic                o_ready,
    output logic                o_pkt_valid,
    output ps2mt_pkg::t_packet  o_pkt
);

    ps2mt_pkg::t_phase  r_phase, n_phase;
    logic [7:0]         r_header, n_header;
    logic [7:0]         r_xbyte, n_xbyte;
    logic               r_pkt_valid;
    ps2mt_pkg::t_packet r_pkt;
    logic               accept;
    logic               pkt_load;

    assign o_ready = !r_pkt_valid || i_adv;
    assign accept  = i_valid && o_ready;

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            case (r_phase)
                ps2mt_pkg::PH_HEADER: begin
                    if (i_byte[ps2mt_pkg::HDR_SYNC_BIT]) begin
                        n_phase = ps2mt_pkg::PH_XBYTE;
                    end
                end
                ps2mt_pkg::PH_XBYTE: n_phase = ps2mt_pkg::PH_YBYTE;
                ps2mt_pkg::PH_YBYTE: n_phase = ps2mt_pkg::PH_HEADER;
                default:             n_phase = ps2mt_pkg::PH_HEADER;
            endcase
        end
    end

    // Byte capture per phase. A header without the sync bit is still kept.
    always_comb begin
        n_header = r_header;
        n_xbyte  = r_xbyte;
        pkt_load = 1'b0;
        if (accept) begin
            case (r_phase)
                ps2mt_pkg::PH_HEADER: n_header = i_byte;
                ps2mt_pkg::PH_XBYTE:  n_xbyte  = i_byte;
                ps2mt_pkg::PH_YBYTE:  pkt_load = 1'b1;
                default:              pkt_load = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ps2mt_pkg::PH_HEADER;
            r_header    <= 8'd0;
            r_xbyte     <= 8'd0;
            r_pkt_valid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_header <= n_header;
            r_xbyte  <= n_xbyte;
            if (pkt_load) begin
                r_pkt_valid <= 1'b1;
            end else if (i_adv) begin
                r_pkt_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pkt_load) begin
            r_pkt.header <= r_header;
            r_pkt.xbyte  <= r_xbyte;
            r_pkt.ybyte  <= i_byte;
        end
    end

    assign o_pkt_valid = r_pkt_valid;
    assign o_pkt       = r_pkt;

endmodule

[design/ps2mt_update.sv]
// Position and button update: applies one packet and holds the result register.
module ps2mt_update #(
    parameter int COORD_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_pkt_valid,
    input  ps2mt_pkg::t_packet                i_pkt,
    input  logic [ps2mt_pkg::LIMIT_W-1:0]     i_x_limit,
    input  logic [ps2mt_pkg::LIMIT_W-1:0]     i_y_limit,
    input  logic                              i_out_ready,
    output logic                              o_adv,
    output logic                              o_out_valid,
    output ps2mt_pkg::t_result                o_out
);

    localparam int SUM_W = COORD_BITS + 1;
    localparam int CMP_W = (COORD_BITS > ps2mt_pkg::LIMIT_W) ? COORD_BITS
                                                              : ps2mt_pkg::LIMIT_W;

    logic [COORD_BITS-1:0] r_pos_x, r_pos_y;
    logic [2:0]            r_prev;
    logic                  r_out_valid;
    ps2mt_pkg::t_result    r_out;

    logic [SUM_W-1:0]  x_sum, y_sum;
    logic [CMP_W-1:0]  x_ext, y_ext, x_lim, y_lim;
    logic [CMP_W-1:0]  x_low, y_low, x_new, y_new;
    logic [1:0]        held;
    logic [2:0]        pattern;
    ps2mt_pkg::t_result n_out;
    logic              load;

    assign o_adv = !r_out_valid || i_out_ready;
    assign load  = i_pkt_valid && o_adv;

    // X moves by the signed delta, Y against it; the extra sum bit absorbs the 256 offset.
    always_comb begin
        x_sum = SUM_W'(r_pos_x) + SUM_W'(i_pkt.xbyte);
        if (i_pkt.header[ps2mt_pkg::HDR_XSGN_BIT]) begin
            x_sum = x_sum - SUM_W'(256);
        end
        y_sum = SUM_W'(r_pos_y) - SUM_W'(i_pkt.ybyte);
        if (i_pkt.header[ps2mt_pkg::HDR_YSGN_BIT]) begin
            y_sum = y_sum + SUM_W'(256);
        end
    end

    // Clamp to one first, then to the limit, so a zero limit gives zero.
    always_comb begin
        x_ext = CMP_W'(x_sum[COORD_BITS-1:0]);
        y_ext = CMP_W'(y_sum[COORD_BITS-1:0]);
        x_lim = CMP_W'(i_x_limit);
        y_lim = CMP_W'(i_y_limit);
        x_low = (x_ext == '0) ? CMP_W'(1) : x_ext;
        y_low = (y_ext == '0) ? CMP_W'(1) : y_ext;
        x_new = (x_low > x_lim) ? x_lim : x_low;
        y_new = (y_low > y_lim) ? y_lim : y_low;
    end

    // The highest numbered pressed button wins.
    always_comb begin
        if (i_pkt.header[ps2mt_pkg::HDR_BTN3_BIT]) begin
            held = ps2mt_pkg::HELD_BTN3;
        end else if (i_pkt.header[ps2mt_pkg::HDR_BTN2_BIT]) begin
            held = ps2mt_pkg::HELD_BTN2;
        end else if (i_pkt.header[ps2mt_pkg::HDR_BTN1_BIT]) begin
            held = ps2mt_pkg::HELD_BTN1;
        end else begin
            held = ps2mt_pkg::HELD_NONE;
        end
        pattern = {held == ps2mt_pkg::HELD_BTN3, held == ps2mt_pkg::HELD_BTN2,
                   held == ps2mt_pkg::HELD_BTN1};
    end

    always_comb begin
        n_out.cursor_x      = x_new[ps2mt_pkg::OUT_W-1:0];
        n_out.cursor_y      = y_new[ps2mt_pkg::OUT_W-1:0];
        n_out.held_button   = held;
        n_out.button_change = (pattern != r_prev);
        n_out.down_edges    = pattern & ~r_prev;
        n_out.up_edges      = r_prev & ~pattern;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_prev      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_adv) begin
                r_out_valid <= i_pkt_valid;
            end
            if (load) begin
                r_pos_x <= x_new[COORD_BITS-1:0];
                r_pos_y <= y_new[COORD_BITS-1:0];
                r_prev  <= pattern;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[design/ps2_mouse_packet_tracker_top.sv]
// A result passes the packet register and then the result register after the request carrying the Y byte is accepted.
// Throughput: one byte per cycle while the framer is ready; the packet register and the result register each
// advance whenever the stage after them is empty or being drained.
// A packet yields one result, so results come at most once per three accepted bytes.
// Reset (synchronous, active low) returns the framer to header search, clears position
// and button history, and loads the X and Y limits with 784 and 584.
module ps2_mouse_packet_tracker_top #(
    parameter int COORD_BITS = 12
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ps2mt_byte_if.sink   i_rx,
    ps2mt_cfg_if.sink    i_cfg,
    ps2mt_result_if.source o_res
);

    logic [ps2mt_pkg::LIMIT_W-1:0] r_x_limit, r_y_limit;
    logic                          pkt_valid;
    ps2mt_pkg::t_packet            pkt;
    logic                          adv;
    ps2mt_pkg::t_result            res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_limit <= ps2mt_pkg::X_LIMIT_RESET;
            r_y_limit <= ps2mt_pkg::Y_LIMIT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                ps2mt_pkg::CFG_X_LIMIT: r_x_limit <= i_cfg.data;
                ps2mt_pkg::CFG_Y_LIMIT: r_y_limit <= i_cfg.data;
                default: begin
                    r_x_limit <= r_x_limit;
                end
            endcase
        end
    end

    ps2mt_framer u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_rx.valid),
        .i_byte      (i_rx.rx_byte),
        .i_adv       (adv),
        .o_ready     (i_rx.ready),
        .o_pkt_valid (pkt_valid),
        .o_pkt       (pkt)
    );

    ps2mt_update #(
        .COORD_BITS (COORD_BITS)
    ) u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pkt_valid (pkt_valid),
        .i_pkt       (pkt),
        .i_x_limit   (r_x_limit),
        .i_y_limit   (r_y_limit),
        .i_out_ready (o_res.ready),
        .o_adv       (adv),
        .o_out_valid (o_res.valid),
        .o_out       (res)
    );

    assign o_res.cursor_x      = res.cursor_x;
    assign o_res.cursor_y      = res.cursor_y;
    assign o_res.held_button   = res.held_button;
    assign o_res.button_change = res.button_change;
    assign o_res.down_edges    = res.down_edges;
    assign o_res.up_edges      = res.up_edges;

endmodule

[design/ps2mt_checker.sv]
// Port-level checker for the PS/2 mouse packet tracker, bound to the top level.
`include "ps2_mouse_packet_tracker_top_macros.svh"

module ps2mt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [ps2mt_pkg::OUT_W-1:0]  i_cursor_x,
    input logic [ps2mt_pkg::OUT_W-1:0]  i_cursor_y,
    input logic [1:0]                    i_held_button,
    input logic                          i_button_change,
    input logic [2:0]                    i_down_edges,
    input logic [2:0]                    i_up_edges
);

    logic [2*ps2mt_pkg::OUT_W+8:0] out_fields;
    logic                          edges_exclusive;
    logic                          edge_seen;
    logic                          none_held;

    assign out_fields = {i_cursor_x, i_cursor_y, i_held_button, i_button_change,
                         i_down_edges, i_up_edges};
    assign edges_exclusive = $onehot0(i_down_edges) && $onehot0(i_up_edges)
                             && ((i_down_edges & i_up_edges) == 3'd0);
    assign edge_seen = ((i_down_edges | i_up_edges) != 3'd0);
    assign none_held = (i_held_button == ps2mt_pkg::HELD_NONE);

    // A stalled result stays offered and unchanged.
    `PS2MT_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    `PS2MT_ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready, $stable(out_fields))

    // Only one button is held at a time, so at most one goes down and one goes up.
    `PS2MT_ASSERT_NOW(a_edges_onehot, i_out_valid, edges_exclusive)

    // A change is flagged exactly when some edge is reported.
    `PS2MT_ASSERT_NOW(a_change_edges, i_out_valid, i_button_change == edge_seen)

    // With no button held, nothing can have gone down.
    `PS2MT_ASSERT_NOW(a_none_no_down, i_out_valid && none_held, i_down_edges == 3'd0)

endmodule

bind ps2_mouse_packet_tracker_top ps2mt_checker u_ps2mt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_cursor_x      (o_res.cursor_x),
    .i_cursor_y      (o_res.cursor_y),
    .i_held_button   (o_res.held_button),
    .i_button_change (o_res.button_change),
    .i_down_edges    (o_res.down_edges),
    .i_up_edges      (o_res.up_edges)
);
